>>> rtl/nbpt_pkg.sv
package nbpt_pkg;

	// default geometry
	localparam int NUM_CLASSES_DEF = 10;
	localparam int IMAGE_SIDE_DEF  = 28;
	localparam int COUNT_BITS_DEF  = 13;

	// operation codes
	localparam logic [1:0] OP_COUNT = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_PRIOR = 2'd2;

	// configuration register indexes
	localparam logic CFG_SMOOTHING_K   = 1'b0;
	localparam logic CFG_FEATURE_VALUE = 1'b1;

	// ink characters
	localparam logic [7:0] CHAR_HASH = 8'h23;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;

	localparam int MILLI      = 1000;
	localparam int MILLI_X2   = 2 * MILLI;
	localparam int QUO_BITS   = 11;          // quotient never exceeds 1000
	localparam int VALUE_BITS = 10;

	localparam logic [3:0] K_RESET    = 4'd1;
	localparam logic       FEAT_RESET = 1'b1;

endpackage

>>> rtl/naive_bayes_pixel_trainer.sv
// Bernoulli naive Bayes trainer for labeled ASCII digit images.
// Input channel (in_valid/in_stall) takes one beat per pixel or query:
//   count beats with an ink character (# or +) bump the ink counter of
//   (class,row,col); last_pixel also bumps the class image count and the total image count.
//   feature queries return (k+c)/(2k+n) and prior queries return
//   class images / all images, both in rounded thousandths.
// Output channel (out_valid/out_stall) carries one beat per query.
// A count beat is one read-modify-write of the ink memory (ADDR, READ,
// WRITE). A query runs ADDR, READ, PREP, MUL, the 11-step restoring
// divider that shares one subtract/compare, and DONE; MUL skips the
// divider when the divisor is zero or the ratio is above one. The next
// beat is taken in the cycle after the result is loaded.
// in_stall stays high while an item is worked on.
// Reset: clears class and total counts, sets k=1 and feature_value=1,
// then sweeps the ink memory to zero, one entry per cycle, over all
// NUM_CLASSES*IMAGE_SIDE*IMAGE_SIDE entries (7840 by default); in_stall is
// high during the sweep. Config writes are taken at any time.
// A stalled result is held in the output register; the next item is still
// accepted, and a following query waits for the register to empty.
module naive_bayes_pixel_trainer #(
	parameter int NUM_CLASSES = nbpt_pkg::NUM_CLASSES_DEF,
	parameter int IMAGE_SIDE  = nbpt_pkg::IMAGE_SIDE_DEF,
	parameter int COUNT_BITS  = nbpt_pkg::COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [3:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [3:0] class_label,
	input  logic [4:0] pixel_row,
	input  logic [4:0] pixel_col,
	input  logic [7:0] pixel_char,
	input  logic       last_pixel,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [9:0] value_milli,
	output logic       divide_by_zero
);

	localparam int PIX      = IMAGE_SIDE * IMAGE_SIDE;
	localparam int DEPTH    = NUM_CLASSES * PIX;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CLS_W    = $clog2(NUM_CLASSES);
	localparam int NW       = COUNT_BITS + 1;
	localparam int RW       = COUNT_BITS + 13;
	localparam int QB       = nbpt_pkg::QUO_BITS;
	localparam int STEP_W   = $clog2(QB);
	localparam int VB       = nbpt_pkg::VALUE_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_ADDR, ST_READ, ST_WRITE, ST_PREP, ST_MUL, ST_DIV, ST_DONE
	} state_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	state_t                state_q;
	logic [ADDR_W-1:0]     clr_q;
	logic [3:0]            k_q;
	logic                  feat_q;

	logic [1:0]            op_q;
	logic [3:0]            cls_q;
	logic [4:0]            row_q;
	logic [4:0]            col_q;
	logic                  ink_q;
	logic                  last_q;
	logic                  cls_ok_q;
	logic                  pos_ok_q;
	logic [ADDR_W-1:0]     addr_q;

	logic [COUNT_BITS-1:0] cls_cnt_q [NUM_CLASSES];
	logic [COUNT_BITS-1:0] total_q;

	logic [NW-1:0]         num_q;
	logic [NW-1:0]         den_q;
	logic [RW-1:0]         rem_q;
	logic [RW-1:0]         vs_q;
	logic [QB-1:0]         quo_q;
	logic [STEP_W-1:0]     step_q;
	logic [VB-1:0]         res_val_q;
	logic                  res_dbz_q;

	logic                  out_valid_q;
	logic [VB-1:0]         value_q;
	logic                  dbz_q;
	logic                  res_load;

	// ink counter memory
	logic [COUNT_BITS-1:0] ink_mem [DEPTH];
	logic [COUNT_BITS-1:0] rdata_q;
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = sat_inc(rdata_q);
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == ST_WRITE && ink_q && pos_ok_q) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ink_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= ink_mem[addr_q];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= nbpt_pkg::K_RESET;
			feat_q <= nbpt_pkg::FEAT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				nbpt_pkg::CFG_SMOOTHING_K:   k_q    <= cfg_data;
				nbpt_pkg::CFG_FEATURE_VALUE: feat_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// operand selection for the divider
	logic [CLS_W-1:0]      cls_idx;
	logic [COUNT_BITS-1:0] n_w;
	logic [COUNT_BITS-1:0] ink_w;
	logic [COUNT_BITS-1:0] c_w;
	logic [NW-1:0]         num_w;
	logic [NW-1:0]         den_w;
	logic                  sub_ok;
	logic [RW-1:0]         sub_w;

	always_comb begin
		cls_idx = cls_q[CLS_W-1:0];
		n_w     = cls_ok_q ? cls_cnt_q[cls_idx] : '0;
		ink_w   = (cls_ok_q && pos_ok_q) ? rdata_q : '0;
		if (feat_q) begin
			c_w = ink_w;
		end else begin
			c_w = (ink_w > n_w) ? '0 : n_w - ink_w;
		end
		if (op_q == nbpt_pkg::OP_PRIOR) begin
			num_w = NW'(n_w);
			den_w = NW'(total_q);
		end else begin
			num_w = NW'(k_q) + NW'(c_w);
			den_w = NW'({k_q, 1'b0}) + NW'(n_w);
		end
		// shared subtract/compare of the restoring divider
		sub_ok = rem_q >= vs_q;
		sub_w  = rem_q - vs_q;
	end

	// result register loads when it is empty or being drained this cycle
	assign res_load       = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign value_milli    = value_q;
	assign divide_by_zero = dbz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				cls_cnt_q[i] <= '0;
			end
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q     <= operation;
						cls_q    <= class_label;
						row_q    <= pixel_row;
						col_q    <= pixel_col;
						ink_q    <= (pixel_char == nbpt_pkg::CHAR_HASH) ||
						            (pixel_char == nbpt_pkg::CHAR_PLUS);
						last_q   <= last_pixel;
						cls_ok_q <= 32'(class_label) < NUM_CLASSES;
						pos_ok_q <= (32'(pixel_row) < IMAGE_SIDE) && (32'(pixel_col) < IMAGE_SIDE);
						state_q  <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					addr_q <= ADDR_W'(32'(cls_q) * PIX + 32'(row_q) * IMAGE_SIDE + 32'(col_q));
					if (op_q == nbpt_pkg::OP_COUNT) begin
						state_q <= cls_ok_q ? ST_READ : ST_IDLE;
					end else if (op_q == nbpt_pkg::OP_QUERY || op_q == nbpt_pkg::OP_PRIOR) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					state_q <= (op_q == nbpt_pkg::OP_COUNT) ? ST_WRITE : ST_PREP;
				end
				ST_WRITE: begin
					if (last_q) begin
						cls_cnt_q[cls_idx] <= sat_inc(cls_cnt_q[cls_idx]);
						total_q            <= sat_inc(total_q);
					end
					state_q <= ST_IDLE;
				end
				ST_PREP: begin
					num_q   <= num_w;
					den_q   <= den_w;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (den_q == '0) begin
						res_val_q <= '0;
						res_dbz_q <= 1'b1;
						state_q   <= ST_DONE;
					end else if (num_q > den_q) begin
						// ratio above one saturates
						res_val_q <= VB'(nbpt_pkg::MILLI);
						res_dbz_q <= 1'b0;
						state_q   <= ST_DONE;
					end else begin
						// round(1000*num/den) = (2000*num + den) / (2*den)
						rem_q     <= RW'(num_q) * RW'(nbpt_pkg::MILLI_X2) + RW'(den_q);
						vs_q      <= RW'(den_q) << QB;
						quo_q     <= '0;
						step_q    <= '0;
						res_dbz_q <= 1'b0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sub_ok) begin
						rem_q <= sub_w;
					end
					quo_q  <= {quo_q[QB-2:0], sub_ok};
					vs_q   <= vs_q >> 1;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(QB - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						value_q <= res_dbz_q ? '0 :
						           (num_q > den_q) ? res_val_q : quo_q[VB-1:0];
						dbz_q   <= res_dbz_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/nbpt_checker.sv
module nbpt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] operation,
	input logic       out_valid,
	input logic       out_stall,
	input logic [9:0] value_milli,
	input logic       divide_by_zero
);

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_milli) &&
		$stable(divide_by_zero))
		else $error("output beat changed while stalled");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> value_milli <= 10'd1000)
		else $error("value_milli above 1000");

	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> value_milli == 10'd0)
		else $error("divide_by_zero with nonzero value");

	// the block works on one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on back-to-back cycles");

	// a count beat never produces a result on its own
	a_count_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == nbpt_pkg::OP_COUNT && !out_valid
		|=> !out_valid)
		else $error("result after count beat");

endmodule

bind naive_bayes_pixel_trainer nbpt_checker u_nbpt_checker (.*);
